// ----- rtl/mandelbrot_smooth_escape_time_defines.svh -----
// Assertion macros for the checker file of the escape-time block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MANDELBROT_SMOOTH_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_SMOOTH_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MSET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mset_pkg.sv -----
// Shared widths, register codes, reset values and unit request/response types
// for the escape-time block. No dependencies.
package mset_pkg;

    localparam int C_W        = 52;   // input point components
    localparam int Z_W        = 64;   // orbit components
    localparam int W_W        = 128;  // exact squares and products
    localparam int HALF_W     = 32;   // multiplier operand width
    localparam int SMOOTH_W   = 33;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_ITER_W = 16;
    localparam int ESC_LIM_W  = 15;
    localparam int MSB_W      = 7;    // bit position within a W_W word
    localparam int MANT_W     = 16;   // log2 fraction bits

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT = 2'd1;

    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST  = 16'd2000;
    localparam logic [ESC_LIM_W-1:0]  ESC_LIMIT_RST = 15'd10000;  // 100.0 * 100.0

    // -1.0 in Q16.16, reported for interior points
    localparam logic signed [SMOOTH_W-1:0] SMOOTH_INTERIOR = -33'sd65536;

    typedef struct packed {
        logic           start;
        logic [Z_W-1:0] a;
        logic [Z_W-1:0] b;
    } t_mac_req;

    typedef struct packed {
        logic           done;
        logic [W_W-1:0] prod;
    } t_mac_rsp;

    typedef struct packed {
        logic           start;
        logic [W_W-1:0] val;
    } t_norm_req;

    typedef struct packed {
        logic              done;
        logic [MSB_W-1:0]  msb;
        logic [MANT_W-1:0] mant;
    } t_norm_rsp;

endpackage

// ----- rtl/mset_in_if.sv -----
// Point channel: valid/ready handshake carrying one complex point per beat.
// Depends on mset_pkg.
interface mset_in_if;
    import mset_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// ----- rtl/mset_out_if.sv -----
// Result channel: valid/ready handshake carrying one escape result per beat.
// Depends on mset_pkg.
interface mset_out_if #(
    parameter int ITER_BITS = 16
);
    import mset_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       escaped;
    logic [ITER_BITS-1:0]       iteration_index;
    logic signed [SMOOTH_W-1:0] smooth_value;

    modport source (output valid, output escaped, output iteration_index,
                    output smooth_value, input ready);
    modport sink   (input valid, input escaped, input iteration_index,
                    input smooth_value, output ready);
endinterface

// ----- rtl/mset_mac.sv -----
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier over four
// partial products, accumulated into a 128-bit register. Depends on mset_pkg.
module mset_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mset_pkg::t_mac_req i_req,
    output mset_pkg::t_mac_rsp o_rsp
);
    import mset_pkg::*;

    logic [Z_W-1:0]      r_a;
    logic [Z_W-1:0]      r_b;
    logic [1:0]          r_step;
    logic                r_run;
    logic                r_pv;
    logic                r_last;
    logic                r_done;
    logic [2*HALF_W-1:0] r_prod;
    logic [1:0]          r_sh;
    logic [W_W-1:0]      r_acc;

    logic [HALF_W-1:0]   a_part;
    logic [HALF_W-1:0]   b_part;
    logic [2*HALF_W-1:0] prod_w;
    logic [W_W-1:0]      prod_sh;

    assign a_part  = r_step[0] ? r_a[Z_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_part  = r_step[1] ? r_b[Z_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign prod_w  = a_part * b_part;
    // weight of the partial product is 32 * (number of high halves used)
    assign prod_sh = {{(W_W-2*HALF_W){1'b0}}, r_prod} << {r_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_pv   <= r_run;
            r_done <= r_pv && r_last;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= 2'd0;
            end else if (r_run) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + prod_sh;
        end
        if (r_run) begin
            r_prod <= prod_w;
            r_sh   <= 2'({1'b0, r_step[0]} + {1'b0, r_step[1]});
            r_last <= (r_step == 2'd3);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ----- rtl/mset_norm.sv -----
// Leading-one normalizer for Mitchell log2: binary search over a 128-bit word,
// one shift stage per cycle. Gives the msb position and the 16 bits below it.
// Depends on mset_pkg.
module mset_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mset_pkg::t_norm_req i_req,
    output mset_pkg::t_norm_rsp o_rsp
);
    import mset_pkg::*;

    logic [W_W-1:0]   r_v;
    logic [MSB_W-1:0] r_sh;
    logic [2:0]       r_k;
    logic             r_run;
    logic             r_done;

    logic [MSB_W-1:0] amt;
    logic             hi_zero;

    assign amt     = MSB_W'(1) << r_k;
    assign hi_zero = ((r_v & ~({W_W{1'b1}} >> amt)) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= r_run && (r_k == '0);
            if (i_req.start) begin
                r_run <= 1'b1;
                r_k   <= 3'(MSB_W - 1);
            end else if (r_run) begin
                r_k <= r_k - 3'd1;
                if (r_k == '0) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v  <= i_req.val;
            r_sh <= '0;
        end else if (r_run && hi_zero) begin
            r_v  <= r_v << amt;
            r_sh <= r_sh + amt;
        end
    end

    // a zero word ends fully shifted, giving position 0 and mantissa 0
    assign o_rsp.done = r_done;
    assign o_rsp.msb  = MSB_W'(W_W - 1) - r_sh;
    assign o_rsp.mant = r_v[W_W-2 -: MANT_W];

endmodule

// ----- rtl/mandelbrot_smooth_escape_time.sv -----
// Escape-time unit: iterates z = z^2 + c from zero for one point at a time and
// reports escape, the pass index and the smooth count i - log2(log2|z|) in Q16.16.
// Each pass is paced by the shared 32x32 multiplier, which forms the twelve
// partial products of zr^2, zi^2 and zr*zi one after another; an escaped point
// then goes through the shared leading-one normalizer for the two Mitchell
// logarithms. The block takes no new point meanwhile, but a finished result
// waits in its own output register.
// Depends on mset_pkg, mset_in_if, mset_out_if, mset_mac and mset_norm.
module mandelbrot_smooth_escape_time #(
    parameter int FRAC_BITS = 48,
    parameter int ITER_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mset_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mset_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mset_in_if.sink                         i_pt,
    mset_out_if.source                      o_res
);
    import mset_pkg::*;

    localparam int LIM_SH = 2 * FRAC_BITS;
    localparam int EXP_W  = 9;
    localparam int L_W    = EXP_W + MANT_W;
    localparam int X_W    = L_W - 2;
    localparam logic signed [EXP_W-1:0] LOG1_OFS = EXP_W'(2 * FRAC_BITS);
    localparam logic signed [EXP_W-1:0] LOG2_OFS = EXP_W'(MANT_W);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_CHK  = 11'b00000000010,
        S_MRR  = 11'b00000000100,
        S_MII  = 11'b00000001000,
        S_SUM  = 11'b00000010000,
        S_CMP  = 11'b00000100000,
        S_MRI  = 11'b00001000000,
        S_UPD  = 11'b00010000000,
        S_LG1  = 11'b00100000000,
        S_LG2  = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state                     r_state, n_state;
    logic [MAX_ITER_W-1:0]      r_max_iter;
    logic [ESC_LIM_W-1:0]       r_esc_lim;
    logic signed [C_W-1:0]      r_cr, n_cr;
    logic signed [C_W-1:0]      r_ci, n_ci;
    logic signed [Z_W-1:0]      r_zr, n_zr;
    logic signed [Z_W-1:0]      r_zi, n_zi;
    logic [MAX_ITER_W-1:0]      r_iter, n_iter;
    logic                       r_ovf, n_ovf;
    logic                       r_esc, n_esc;
    logic [W_W-1:0]             r_sq, n_sq;
    logic [W_W-1:0]             r_m, n_m;
    logic signed [W_W-1:0]      r_d, n_d;
    logic signed [SMOOTH_W-1:0] r_sm, n_sm;
    logic                       r_ovld, n_ovld;
    logic                       r_oesc, n_oesc;
    logic [MAX_ITER_W-1:0]      r_oiter, n_oiter;
    logic signed [SMOOTH_W-1:0] r_osm, n_osm;

    t_mac_req  mac_req;
    t_mac_rsp  mac_rsp;
    t_norm_req norm_req;
    t_norm_rsp norm_rsp;

    logic [Z_W-1:0]          mag_zr;
    logic [Z_W-1:0]          mag_zi;
    logic [W_W-1:0]          lim;
    logic                    esc_hit;
    logic signed [W_W-1:0]   sh_i;
    logic signed [W_W-1:0]   sh_r;
    logic signed [W_W-1:0]   sum_i;
    logic signed [W_W-1:0]   sum_r;
    logic                    fit_i;
    logic                    fit_r;
    logic [Z_W-1:0]          sat_i;
    logic [Z_W-1:0]          sat_r;
    logic signed [EXP_W-1:0] e1;
    logic signed [L_W-1:0]   l1;
    logic [X_W-1:0]          x1;
    logic signed [EXP_W-1:0] e2;
    logic signed [L_W-1:0]   lx;
    logic signed [33:0]      sm_w;

    mset_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    mset_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_rsp   (norm_rsp)
    );

    assign mag_zr  = r_zr[Z_W-1] ? (~r_zr + 64'd1) : r_zr;
    assign mag_zi  = r_zi[Z_W-1] ? (~r_zi + 64'd1) : r_zi;
    assign lim     = W_W'(r_esc_lim) << LIM_SH;
    assign esc_hit = r_ovf || (r_m > lim);

    // next z: floor shifts of the exact products, plus c, saturated to 64 bits
    assign sh_i  = $signed(r_sq) >>> (FRAC_BITS - 1);
    assign sh_r  = r_d >>> FRAC_BITS;
    assign sum_i = sh_i + W_W'(r_ci);
    assign sum_r = sh_r + W_W'(r_cr);
    assign fit_i = (&sum_i[W_W-1:Z_W-1]) || !(|sum_i[W_W-1:Z_W-1]);
    assign fit_r = (&sum_r[W_W-1:Z_W-1]) || !(|sum_r[W_W-1:Z_W-1]);
    assign sat_i = sum_i[W_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
    assign sat_r = sum_r[W_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};

    // log2|z|^2 in Q.16, halved; values below 2 LSB clamp to one LSB
    assign e1 = $signed({2'b00, norm_rsp.msb}) - LOG1_OFS;
    assign l1 = {e1, norm_rsp.mant};
    assign x1 = (!l1[L_W-1] && (|l1[L_W-2:1])) ? l1[L_W-2:1] : X_W'(1);

    assign e2   = $signed({2'b00, norm_rsp.msb}) - LOG2_OFS;
    assign lx   = {e2, norm_rsp.mant};
    assign sm_w = $signed({2'b00, r_iter, {MANT_W{1'b0}}}) - 34'(lx);

    assign i_pt.ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_iter   = r_iter;
        n_ovf    = r_ovf;
        n_esc    = r_esc;
        n_sq     = r_sq;
        n_m      = r_m;
        n_d      = r_d;
        n_sm     = r_sm;
        n_ovld   = r_ovld;
        n_oesc   = r_oesc;
        n_oiter  = r_oiter;
        n_osm    = r_osm;
        mac_req  = '{start: 1'b0, a: mag_zr, b: mag_zr};
        norm_req = '{start: 1'b0, val: r_m};

        if (r_ovld && o_res.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_cr    = i_pt.c_real;
                    n_ci    = i_pt.c_imag;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_iter  = '0;
                    n_ovf   = 1'b0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_iter < r_max_iter) begin
                    mac_req.start = 1'b1;
                    n_state       = S_MRR;
                end else begin
                    n_esc   = 1'b0;
                    n_sm    = SMOOTH_INTERIOR;
                    n_state = S_DONE;
                end
            end
            S_MRR: begin
                if (mac_rsp.done) begin
                    n_sq     = mac_rsp.prod;
                    mac_req  = '{start: 1'b1, a: mag_zi, b: mag_zi};
                    n_state  = S_MII;
                end
            end
            S_MII: begin
                if (mac_rsp.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_m     = r_sq + mac_rsp.prod;
                n_d     = $signed(r_sq - mac_rsp.prod);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (esc_hit) begin
                    n_esc          = 1'b1;
                    norm_req.start = 1'b1;
                    n_state        = S_LG1;
                end else begin
                    mac_req = '{start: 1'b1, a: mag_zr, b: mag_zi};
                    n_state = S_MRI;
                end
            end
            S_MRI: begin
                if (mac_rsp.done) begin
                    // holds 2*zr*zi scaled by 2^(2F-1) once shifted by F-1
                    n_sq    = (r_zr[Z_W-1] ^ r_zi[Z_W-1]) ? (~mac_rsp.prod + 128'd1)
                                                          : mac_rsp.prod;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_zi    = fit_i ? sum_i[Z_W-1:0] : sat_i;
                n_zr    = fit_r ? sum_r[Z_W-1:0] : sat_r;
                n_ovf   = r_ovf || !fit_i || !fit_r;
                n_iter  = r_iter + 16'd1;
                n_state = S_CHK;
            end
            S_LG1: begin
                if (norm_rsp.done) begin
                    norm_req = '{start: 1'b1, val: W_W'(x1)};
                    n_state  = S_LG2;
                end
            end
            S_LG2: begin
                if (norm_rsp.done) begin
                    n_sm    = sm_w[SMOOTH_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovld || o_res.ready) begin
                    n_ovld  = 1'b1;
                    n_oesc  = r_esc;
                    n_oiter = r_iter;
                    n_osm   = r_sm;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovld     <= 1'b0;
            r_max_iter <= MAX_ITER_RST;
            r_esc_lim  <= ESC_LIMIT_RST;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_ITER:  r_max_iter <= i_cfg_data[MAX_ITER_W-1:0];
                    REG_ESC_LIMIT: r_esc_lim  <= i_cfg_data[ESC_LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_iter  <= n_iter;
        r_ovf   <= n_ovf;
        r_esc   <= n_esc;
        r_sq    <= n_sq;
        r_m     <= n_m;
        r_d     <= n_d;
        r_sm    <= n_sm;
        r_oesc  <= n_oesc;
        r_oiter <= n_oiter;
        r_osm   <= n_osm;
    end

    assign o_res.valid           = r_ovld;
    assign o_res.escaped         = r_oesc;
    assign o_res.iteration_index = ITER_BITS'(r_oiter);
    assign o_res.smooth_value    = r_osm;

endmodule

// ----- rtl/mset_checker.sv -----
// Port-level checks for the escape-time block, attached to the top by bind.
// Depends on mset_pkg and mandelbrot_smooth_escape_time_defines.svh.
`include "mandelbrot_smooth_escape_time_defines.svh"

module mset_checker #(
    parameter int ITER_BITS = 16
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   i_in_ready,
    input logic                                   i_out_valid,
    input logic                                   i_out_ready,
    input logic                                   i_out_escaped,
    input logic [ITER_BITS-1:0]                   i_out_iter,
    input logic signed [mset_pkg::SMOOTH_W-1:0]   i_out_smooth
);
    import mset_pkg::*;

    // one point at a time: a taken point makes the unit busy
    `MSET_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "point taken while a point is in flight")

    `MSET_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_escaped) && $stable(i_out_iter) && $stable(i_out_smooth), "stalled result beat changed")

    `MSET_ASSERT_IMP(a_interior_smooth, i_clk, i_rst_n, i_out_valid && !i_out_escaped, i_out_smooth == SMOOTH_INTERIOR, "interior result without smooth value of -1.0")

    // a fresh result only comes out of a busy unit
    `MSET_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result appeared while unit was idle")

endmodule

bind mandelbrot_smooth_escape_time mset_checker #(
    .ITER_BITS (ITER_BITS)
) u_mset_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pt.valid),
    .i_in_ready    (i_pt.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_escaped (o_res.escaped),
    .i_out_iter    (o_res.iteration_index),
    .i_out_smooth  (o_res.smooth_value)
);

// ----- tb/tb_mandelbrot_smooth_escape_time.sv -----
`timescale 1ns / 100ps
// Self-checking bench for mandelbrot_smooth_escape_time: directed corner points, then
// random points over several register settings and handshake idle patterns.
// Depends on mset_pkg, mset_in_if, mset_out_if and the block's RTL.
module tb_mandelbrot_smooth_escape_time;
    import mset_pkg::*;

    localparam int FRAC_BITS = 48;
    localparam int ITER_BITS = 16;

    localparam longint Q_ONE = longint'(1) << FRAC_BITS;
    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

    // indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
    } t_point;

    typedef struct packed {
        logic                escaped;
        logic [ITER_BITS-1:0] idx;
        logic [SMOOTH_W-1:0] smooth;
    } t_escape;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mset_in_if pt_if ();
    mset_out_if #(.ITER_BITS(ITER_BITS)) res_if ();

    mandelbrot_smooth_escape_time #(
        .FRAC_BITS(FRAC_BITS),
        .ITER_BITS(ITER_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pt      (pt_if),
        .o_res     (res_if)
    );

    // shadow copy of the block's registers
    logic [MAX_ITER_W-1:0] max_iter_cfg;
    logic [ESC_LIM_W-1:0]  esc_lim_cfg;

    t_point  points_q[$];
    t_escape escape_exp_q[$];
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned mismatch_count;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic pt_beat;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned msb_pos(input logic [W_W-1:0] v);
        int unsigned p;
        p = 0;
        for (int k = 0; k < W_W; k++)
            if (v[k]) p = k;
        return p;
    endfunction

    // i - log2(log2|z|) in Q16.16, both logs by leading one plus linear mantissa
    function automatic logic [SMOOTH_W-1:0] smooth_count(input int unsigned n_pass,
                                                          input logic [W_W-1:0] m);
        int unsigned p, q;
        logic [W_W-1:0] sh;
        longint l, lx, res;
        longint unsigned x;
        p = msb_pos(m);
        if (p >= 16) sh = m >> (p - 16);
        else sh = m << (16 - p);
        l = (longint'(p) - 2 * FRAC_BITS) * 65536 + longint'(sh[15:0]);
        // halve for |z|; a log below 2 LSB clamps to one LSB
        if (l >= 2) x = l >>> 1;
        else x = 1;
        q = msb_pos(W_W'(x));
        lx = (longint'(q) - 16) * 65536 + longint'(((x << 16) >> q) - 64'd65536);
        res = longint'(n_pass) * 65536 - lx;
        return res[SMOOTH_W-1:0];
    endfunction

    // {overflow, value}: 128-bit sum clamped to the 64-bit range
    function automatic logic [Z_W:0] add_clamp(input logic signed [W_W-1:0] v,
                                               input logic signed [Z_W-1:0] c);
        logic signed [W_W-1:0] s;
        s = v + W_W'(c);
        if (s[W_W-1:Z_W-1] == {(W_W-Z_W+1){s[W_W-1]}}) return {1'b0, s[Z_W-1:0]};
        return {1'b1, s[W_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}}};
    endfunction

    function automatic t_escape predict_escape(input logic signed [C_W-1:0] c_re,
                                               input logic signed [C_W-1:0] c_im);
        t_escape r;
        logic signed [Z_W-1:0] zr, zi, cr, ci;
        logic signed [W_W-1:0] wr, wi, sq_r, sq_i;
        logic [W_W-1:0] mag2, lim;
        logic [Z_W:0] nr, ni;
        logic sat;
        cr = Z_W'(c_re);
        ci = Z_W'(c_im);
        zr = '0;
        zi = '0;
        sat = 1'b0;
        lim = W_W'(esc_lim_cfg) << (2 * FRAC_BITS);
        for (int unsigned i = 0; i < max_iter_cfg; i++) begin
            wr = W_W'(zr);
            wi = W_W'(zi);
            sq_r = wr * wr;
            sq_i = wi * wi;
            mag2 = sq_r + sq_i;
            if (sat || mag2 > lim) begin
                r.escaped = 1'b1;
                r.idx = i[ITER_BITS-1:0];
                r.smooth = smooth_count(i, mag2);
                return r;
            end
            ni = add_clamp((wr * wi) >>> (FRAC_BITS - 1), ci);
            nr = add_clamp((sq_r - sq_i) >>> FRAC_BITS, cr);
            sat = sat | ni[Z_W] | nr[Z_W];
            zi = ni[Z_W-1:0];
            zr = nr[Z_W-1:0];
        end
        r.escaped = 1'b0;
        r.idx = max_iter_cfg[ITER_BITS-1:0];
        r.smooth = SMOOTH_INTERIOR;
        return r;
    endfunction

    function automatic t_point random_point();
        t_point p;
        int unsigned kind;
        logic [63:0] r0, r1;
        kind = $urandom_range(99);
        r0 = {$urandom, $urandom};
        r1 = {$urandom, $urandom};
        if (kind < 60) begin
            // window around the set, where escape times vary most
            p.re = C_W'(-2 * Q_ONE + longint'(r0 % (5 * Q_ONE / 2)));
            p.im = C_W'(-(5 * Q_ONE / 4) + longint'(r1 % (5 * Q_ONE / 2)));
        end else if (kind < 85) begin
            p.re = C_W'(-4 * Q_ONE + longint'(r0 % (8 * Q_ONE + 1)));
            p.im = C_W'(-4 * Q_ONE + longint'(r1 % (8 * Q_ONE + 1)));
        end else begin
            p.re = r0[C_W-1:0];
            p.im = r1[C_W-1:0];
        end
        return p;
    endfunction

    task automatic push_point(input longint re, input longint im);
        t_point p;
        p.re = C_W'(re);
        p.im = C_W'(im);
        points_q.push_back(p);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_ITER: max_iter_cfg = data;
            REG_ESC_LIMIT: esc_lim_cfg = data[ESC_LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (n_checked != n_sent) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [SMOOTH_W-1:0] exp_v,
                               input logic [SMOOTH_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // point driver
    always @(negedge i_clk) begin
        t_point cur;
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || pt_beat) begin
            if (points_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur = points_q.pop_front();
                pt_if.valid <= 1'b1;
                pt_if.c_real <= cur.re;
                pt_if.c_imag <= cur.im;
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // beat monitor: predict on input beats, compare on result beats
    always @(posedge i_clk) begin
        t_escape exp_r;
        pt_beat = i_rst_n && pt_if.valid && pt_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (escape_exp_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %b %h %h", $time,
                         res_if.escaped, res_if.iteration_index, res_if.smooth_value);
                mismatch_count++;
            end else begin
                exp_r = escape_exp_q.pop_front();
                n_checked++;
                check_field("escaped", SMOOTH_W'(exp_r.escaped), SMOOTH_W'(res_if.escaped));
                check_field("iteration_index", SMOOTH_W'(exp_r.idx),
                            SMOOTH_W'(res_if.iteration_index));
                check_field("smooth_value", exp_r.smooth, res_if.smooth_value);
            end
        end
        if (pt_beat) escape_exp_q.push_back(predict_escape(pt_if.c_real, pt_if.c_imag));
    end

    initial begin
        real c_ov;
        logic [CFG_DATA_W-1:0] lim_data;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.c_real = '0;
        pt_if.c_imag = '0;
        res_if.ready = 1'b0;
        pt_beat = 1'b0;
        max_iter_cfg = MAX_ITER_RST;
        esc_lim_cfg = ESC_LIMIT_RST;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        n_sent = 0;
        n_checked = 0;
        mismatch_count = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: interior points run the full 2000 passes
        push_point(0, 0);
        push_point(-Q_ONE, 0);
        push_point(-2 * Q_ONE, 0);
        push_point(Q_ONE / 4, 0);
        push_point(longint'(C_MAX), longint'(C_MAX));
        push_point(longint'(C_MIN), longint'(C_MIN));
        push_point(longint'(C_MAX), longint'(C_MIN));
        push_point(4 * Q_ONE, -4 * Q_ONE);
        push_point(Q_ONE / 2, Q_ONE / 2);
        push_point(-3 * Q_ONE / 4, Q_ONE / 10);
        wait_drained();

        // no passes at all
        write_reg(REG_MAX_ITER, 16'd0);
        write_reg(REG_ESC_LIMIT, 16'd0);
        push_point(Q_ONE, Q_ONE);
        push_point(0, 0);
        wait_drained();

        // zero escape radius: a tiny |z| gives a non-positive log2|z|
        write_reg(REG_MAX_ITER, 16'd1);
        push_point(longint'(C_MAX), 0);
        wait_drained();
        write_reg(REG_MAX_ITER, 16'd3);
        push_point(1, 0);
        push_point(0, -1);
        push_point(0, 0);
        wait_drained();

        // small radii; writes to unused indexes must change nothing
        write_reg(REG_MAX_ITER, 16'd20);
        write_reg(REG_ESC_LIMIT, 16'd1);
        write_reg(REG_SPARE_A, 16'd7);
        write_reg(REG_SPARE_B, 16'hFFFF);
        push_point(Q_ONE / 2, 0);
        push_point(-Q_ONE / 8, Q_ONE / 3);
        wait_drained();
        write_reg(REG_ESC_LIMIT, 16'd3);
        push_point(Q_ONE / 2, -Q_ONE / 2);
        wait_drained();

        // top settings, bit 15 of the limit data is dropped; only fast escapes here
        write_reg(REG_MAX_ITER, 16'hFFFF);
        write_reg(REG_ESC_LIMIT, 16'hFFFF);
        // real orbit tuned so z3 sits just inside the radius and z3^2 + c overflows
        c_ov = 3.2;
        repeat (30) c_ov = (-1.0 + $sqrt(1.0 + 4.0 * $sqrt(181.0135 - c_ov))) / 2.0;
        push_point(longint'(c_ov * 2.0 ** FRAC_BITS), 0);
        push_point(longint'(C_MIN), 0);
        push_point(0, longint'(C_MAX));
        push_point(3 * Q_ONE, Q_ONE);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_MAX_ITER, CFG_DATA_W'($urandom_range(1, 64)));
            case ($urandom_range(3))
                0: lim_data = 16'd4;
                1: lim_data = CFG_DATA_W'(ESC_LIMIT_RST);
                2: lim_data = 16'd16384;
                default: lim_data = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(REG_ESC_LIMIT, lim_data);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            repeat (40) begin
                t_point p;
                p = random_point();
                push_point(longint'(p.re), longint'(p.im));
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && escape_exp_q.size() == 0) begin
            $display("PASS mandelbrot_smooth_escape_time");
        end else begin
            $display("FAIL mandelbrot_smooth_escape_time");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL mandelbrot_smooth_escape_time");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mset_pkg.sv
rtl/mset_in_if.sv
rtl/mset_out_if.sv
rtl/mset_mac.sv
rtl/mset_norm.sv
rtl/mandelbrot_smooth_escape_time.sv
rtl/mset_checker.sv
tb/tb_mandelbrot_smooth_escape_time.sv
